@@ rtl/pfe_pkg.sv @@
// Shared types and codes for the protobuf field encoder.
// No dependencies; every rtl module refers to this package by scoped names.
`timescale 1ns / 1ps

package pfe_pkg;

  // Request kinds carried on in_tuser; the two low bits double as the wire type.
  localparam logic [1:0] REQ_VARINT = 2'd0;
  localparam logic [1:0] REQ_FIXED64 = 2'd1;
  localparam logic [1:0] REQ_LENGTH = 2'd2;
  localparam logic [1:0] REQ_RAW = 2'd3;

  localparam int FNUM_W = 29;
  localparam int VALUE_W = 64;
  localparam int TAG_W = 32;
  localparam int BYTE_W = 8;
  localparam int GROUP_W = 7;
  localparam int IN_DATA_W = 96;

  typedef logic [1:0] req_type_t;

  // One classified request, handed from the front end to the serializer.
  typedef struct packed {
    req_type_t kind;
    logic [TAG_W-1:0] tag;
    logic [VALUE_W-1:0] value;
  } pfe_cmd_t;

endpackage

@@ rtl/pfe_front.sv @@
// Front end: accept request items, build the tag word and classify the request.
// Depends on pfe_pkg; feeds pfe_queue.
`timescale 1ns / 1ps

module pfe_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pfe_pkg::req_type_t in_kind,
  input  logic [pfe_pkg::FNUM_W-1:0] in_fnum,
  input  logic [pfe_pkg::VALUE_W-1:0] in_value,
  output logic push_valid,
  input  logic push_ready,
  output pfe_pkg::pfe_cmd_t push_cmd
);

  logic hold_r;
  logic hold_nxt;
  pfe_pkg::pfe_cmd_t cmd_r;

  assign in_ready = !hold_r || push_ready;
  assign push_valid = hold_r;
  assign push_cmd = cmd_r;

  always_comb begin
    hold_nxt = hold_r;
    if (hold_r && push_ready) begin
      hold_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  // Tag = field number shifted left 3 with the wire type in the low bits.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.kind <= in_kind;
      cmd_r.tag <= {in_fnum, 1'b0, in_kind};
      cmd_r.value <= in_value;
    end
  end

endmodule

@@ rtl/pfe_queue.sv @@
// Short command queue between the front end and the serializer.
// Depends on pfe_pkg for the command type.
`timescale 1ns / 1ps

module pfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  pfe_pkg::pfe_cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output pfe_pkg::pfe_cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfe_pkg::pfe_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/pfe_serializer.sv @@
// Back end: turn a command into tag and body bytes, or one raw byte, one per cycle unless stalled.
// Depends on pfe_pkg; drains pfe_queue and owns the output register.
`timescale 1ns / 1ps

module pfe_serializer (
  input  logic clk,
  input  logic rst_n,
  input  logic pop_valid,
  output logic pop_ready,
  input  pfe_pkg::pfe_cmd_t pop_cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [pfe_pkg::BYTE_W-1:0] out_byte,
  output logic out_last
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TAG = 3'd1;
  localparam logic [2:0] PH_VAR = 3'd2;
  localparam logic [2:0] PH_FIX = 3'd3;
  localparam logic [2:0] PH_RAW = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  pfe_pkg::req_type_t kind_r, kind_nxt;
  logic [pfe_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [pfe_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic vld_r, vld_nxt;
  logic [pfe_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic last_r, last_nxt;
  logic slot_free;
  logic tag_more, val_more;

  assign slot_free = !vld_r || out_ready;
  assign pop_ready = (phase_r == PH_IDLE);
  assign out_valid = vld_r;
  assign out_byte = byte_r;
  assign out_last = last_r;
  assign tag_more = |tag_r[pfe_pkg::TAG_W-1:pfe_pkg::GROUP_W];
  assign val_more = |val_r[pfe_pkg::VALUE_W-1:pfe_pkg::GROUP_W];

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt = kind_r;
    tag_nxt = tag_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    vld_nxt = vld_r && !out_ready;
    byte_nxt = byte_r;
    last_nxt = last_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (pop_valid) begin
          kind_nxt = pop_cmd.kind;
          tag_nxt = pop_cmd.tag;
          val_nxt = pop_cmd.value;
          cnt_nxt = '0;
          phase_nxt = (pop_cmd.kind == pfe_pkg::REQ_RAW) ? PH_RAW : PH_TAG;
        end
      end
      PH_TAG: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          byte_nxt = {tag_more, tag_r[pfe_pkg::GROUP_W-1:0]};
          last_nxt = 1'b0;
          if (tag_more) begin
            tag_nxt = tag_r >> pfe_pkg::GROUP_W;
          end else begin
            phase_nxt = (kind_r == pfe_pkg::REQ_FIXED64) ? PH_FIX : PH_VAR;
          end
        end
      end
      PH_VAR: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          byte_nxt = {val_more, val_r[pfe_pkg::GROUP_W-1:0]};
          last_nxt = !val_more;
          val_nxt = val_r >> pfe_pkg::GROUP_W;
          if (!val_more) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_FIX: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          byte_nxt = val_r[pfe_pkg::BYTE_W-1:0];
          last_nxt = (cnt_r == 3'd7);
          val_nxt = val_r >> pfe_pkg::BYTE_W;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_RAW: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          byte_nxt = val_r[pfe_pkg::BYTE_W-1:0];
          last_nxt = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    tag_r <= tag_nxt;
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

@@ rtl/protobuf_field_encoder.sv @@
// Top level of the protobuf field encoder: front end, command queue, serializer.
// Depends on pfe_pkg, pfe_front, pfe_queue and pfe_serializer.
`timescale 1ns / 1ps

// Usage:
//   in_* is a request stream: in_tuser carries the request kind (varint, fixed64,
//   length header, raw byte), in_tdata the field number and the 64-bit value.
//   out_* is a byte stream: out_tdata is one serialized byte, out_tlast marks
//   the final byte of each request.
//   A request yields 1 to 15 bytes: tag varint (1 to 5 bytes) then the body
//   (varint 1 to 10 bytes, fixed64 8 bytes), or one byte for a raw request.
//   The serializer emits one byte per cycle while out_tready allows, and
//   returns to its idle state after each request to load the next command.
//   The first byte reaches out_tvalid through the front register, the queue,
//   the serializer load and the output register.
//   The front end keeps accepting requests into the FIFO_DEPTH-entry queue
//   while the serializer works, so short bursts of requests do not stall.
//   When the receiver holds out_tready low, the output register holds its byte,
//   the serializer halts, and in_tready falls once the queue and front register fill.
//   Synchronous active-low reset empties the queue and the output register.

module protobuf_field_encoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [95:0] in_tdata,   // [28:0] field_number, [92:29] field_value, [95:93] zero
  input  logic [1:0] in_tuser,    // [1:0] req_type
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic out_tlast          // last_byte
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  pfe_pkg::pfe_cmd_t push_cmd, pop_cmd;
  logic [pfe_pkg::IN_DATA_W-1:0] in_data;

  assign in_data = in_tdata;

  // Accept and classify requests; pad bits of in_tdata are ignored.
  pfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_fnum    (in_data[pfe_pkg::FNUM_W-1:0]),
    .in_value   (in_data[pfe_pkg::FNUM_W+pfe_pkg::VALUE_W-1:pfe_pkg::FNUM_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decouple the request side from the byte side.
  pfe_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Emit tag and body bytes (or one raw byte) through the output register, one per cycle while out_tready allows.
  pfe_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

@@ dv/protobuf_field_encoder_test.sv @@
// Self-checking bench for protobuf_field_encoder: random request stream in, byte stream out.
// A scoreboard class predicts the serialized bytes of each accepted request.
// Depends on pfe_pkg and the rtl under rtl/.
`timescale 1ns / 1ps

module protobuf_field_encoder_test;

  localparam int IDLE_PCT = 38;      // chance per cycle that a side idles
  localparam int HOLD_CYCLES = 300;  // receiver hold-off that fills the queue
  localparam int STALL_LIMIT = 2000; // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 20;  // settle time after the last expected byte
  localparam int RANDOM_ITEMS = 350;

  // Expected byte stream of the encoder, one entry per output item.
  class pfe_byte_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic last;
    } enc_byte_t;

    enc_byte_t expected_q[$];
    int errors;
    int bytes_checked;

    // Base-128 varint, low group first, continuation bit on all but the final byte.
    static function void encode_varint(ref enc_byte_t q[$], input logic [63:0] v);
      enc_byte_t b;
      b.last = 1'b0;
      while (v >= 64'd128) begin
        b.data = {1'b1, v[6:0]};
        q = {q, b};
        v = v >> 7;
      end
      b.data = v[7:0];
      q = {q, b};
    endfunction

    function void note_request(pfe_pkg::req_type_t kind, logic [pfe_pkg::FNUM_W-1:0] fnum,
                               logic [pfe_pkg::VALUE_W-1:0] val);
      enc_byte_t item_q[$];
      enc_byte_t b;
      logic [pfe_pkg::TAG_W-1:0] tag;
      tag = {fnum, 1'b0, kind};
      b.last = 1'b0;
      if (kind == pfe_pkg::REQ_RAW) begin
        b.data = val[7:0];
        item_q = {item_q, b};
      end else begin
        encode_varint(item_q, {32'd0, tag});
        if (kind == pfe_pkg::REQ_FIXED64) begin
          for (int i = 0; i < 8; i++) begin
            b.data = val[8*i +: 8];
            item_q = {item_q, b};
          end
        end else begin
          encode_varint(item_q, val);
        end
      end
      item_q[item_q.size()-1].last = 1'b1;
      expected_q = {expected_q, item_q};
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      enc_byte_t exp_b;
      bytes_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte expected=none actual=%02h last=%0b", $time, data, last);
        return;
      end
      exp_b = expected_q.pop_front();
      if (data !== exp_b.data) begin
        errors++;
        $display("%0t: byte mismatch expected=%02h actual=%02h", $time, exp_b.data, data);
      end
      if (last !== exp_b.last) begin
        errors++;
        $display("%0t: tlast mismatch expected=%0b actual=%0b", $time, exp_b.last, last);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;   // [28:0] field_number, [92:29] field_value, [95:93] zero
  logic [1:0] in_tuser = '0;    // [1:0] req_type
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;        // [7:0] out_byte
  logic out_tlast;              // last_byte

  pfe_byte_scoreboard sb = new;

  // Stimulus shaping flags, written by the main sequence only.
  logic calm = 1'b0;       // no idling on either side while set
  logic hold_req = 1'b0;   // ask the receiver for one long hold-off

  int kind_count[4] = '{default: 0};
  int idle_cycles = 0;

  protobuf_field_encoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #1 clk = ~clk;

  // Receiver: random back-pressure, one long hold-off on request, none while calm.
  int hold_left = 0;
  bit hold_started = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check every byte the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d bytes outstanding", $time,
               STALL_LIMIT, sb.outstanding());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request, idling at random first; keep tvalid high on exit so that
  // back-to-back requests without random idling never drop it.
  task automatic send_request(pfe_pkg::req_type_t kind, logic [pfe_pkg::FNUM_W-1:0] fnum,
                              logic [pfe_pkg::VALUE_W-1:0] val);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, val, fnum};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, fnum, val);
    kind_count[kind]++;
  endtask

  // Field numbers spread over every tag length, one to five bytes.
  function automatic logic [pfe_pkg::FNUM_W-1:0] random_field_number();
    int unsigned bits;
    logic [31:0] mask;
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0: bits = 4;
      1: bits = 11;
      2: bits = 18;
      3: bits = 25;
      default: bits = 29;
    endcase
    mask = (32'd1 << bits) - 32'd1;
    r = $urandom & mask;
    return r[pfe_pkg::FNUM_W-1:0];
  endfunction

  // Values of random bit length so every varint size comes up.
  function automatic logic [pfe_pkg::VALUE_W-1:0] random_value();
    int unsigned len;
    logic [63:0] v;
    len = $urandom_range(0, 64);
    v = {$urandom, $urandom};
    if (len == 0) return '0;
    return v >> (64 - len);
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero and all-ones fields, every request kind, tag lengths one to
    // five bytes at their boundaries, varint size boundaries, raw byte with junk
    // in the ignored bits, and a double bit pattern.
    send_request(pfe_pkg::REQ_VARINT, 29'd0, 64'd0);
    send_request(pfe_pkg::REQ_VARINT, 29'h1fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(pfe_pkg::REQ_FIXED64, 29'd0, 64'd0);
    send_request(pfe_pkg::REQ_FIXED64, 29'h1fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(pfe_pkg::REQ_FIXED64, 29'd1, 64'h0123_4567_89ab_cdef);
    send_request(pfe_pkg::REQ_FIXED64, 29'd7, 64'h3ff0_0000_0000_0000);
    send_request(pfe_pkg::REQ_LENGTH, 29'd0, 64'd0);
    send_request(pfe_pkg::REQ_LENGTH, 29'h1fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(pfe_pkg::REQ_LENGTH, 29'd15, 64'd127);
    send_request(pfe_pkg::REQ_VARINT, 29'd16, 64'd128);
    send_request(pfe_pkg::REQ_VARINT, 29'd2047, 64'd16383);
    send_request(pfe_pkg::REQ_VARINT, 29'd2048, 64'd16384);
    send_request(pfe_pkg::REQ_LENGTH, 29'd262143, 64'h7fff_ffff_ffff_ffff);
    send_request(pfe_pkg::REQ_LENGTH, 29'd262144, 64'h8000_0000_0000_0000);
    send_request(pfe_pkg::REQ_VARINT, 29'd33554431, 64'h00ff_ffff_ffff_ffff);
    send_request(pfe_pkg::REQ_VARINT, 29'd33554432, 64'h0100_0000_0000_0000);
    send_request(pfe_pkg::REQ_RAW, 29'd0, 64'd0);
    send_request(pfe_pkg::REQ_RAW, 29'h1fff_ffff, 64'hffff_ffff_ffff_ff00);
    send_request(pfe_pkg::REQ_RAW, 29'd5, 64'h0000_0000_0000_00ff);
    send_request(pfe_pkg::REQ_RAW, 29'd123, {$urandom, $urandom});

    // Random: one long receiver hold-off early on, then a calm stretch with
    // no idling on either side, then random idling again.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) hold_req = 1'b1;
      if (i == 120) calm = 1'b1;
      if (i == 220) calm = 1'b0;
      send_request(pfe_pkg::req_type_t'($urandom_range(0, 3)), random_field_number(),
                   random_value());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain: wait for every expected byte, then watch for stray ones.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d varint, %0d fixed64, %0d length header, %0d raw byte",
             kind_count[pfe_pkg::REQ_VARINT], kind_count[pfe_pkg::REQ_FIXED64],
             kind_count[pfe_pkg::REQ_LENGTH], kind_count[pfe_pkg::REQ_RAW]);
    $display("Bytes checked: %0d, mismatches: %0d", sb.bytes_checked, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pfe_pkg.sv
rtl/pfe_front.sv
rtl/pfe_queue.sv
rtl/pfe_serializer.sv
rtl/protobuf_field_encoder.sv
dv/protobuf_field_encoder_test.sv
